/* design/assert_macros.svh */
// assertion helpers, clocked with an asynchronous active-low reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

/* design/dbus_pkg.sv */
package dbus_pkg;

  localparam int unsigned FRAME_BYTES  = 18;
  localparam int unsigned BUFFER_BYTES = 36;
  localparam int unsigned COUNT_W      = 6;
  localparam int unsigned STORE_IDX_W  = 5;

  localparam logic [1:0] REG_CHANNEL_OFFSET = 2'd0;
  localparam logic [1:0] REG_ERROR_LIMIT    = 2'd1;
  localparam logic [1:0] REG_SWITCH_DOWN    = 2'd2;

  localparam logic [10:0] OFFSET_RESET = 11'd1024;
  localparam logic [10:0] LIMIT_RESET  = 11'd660;
  localparam logic [1:0]  SWDOWN_RESET = 2'd2;

  localparam logic ACTION_BYTE = 1'b0;
  localparam logic ACTION_IDLE = 1'b1;

  typedef logic [FRAME_BYTES-1:0][7:0] frame_t;

  typedef struct packed {
    logic       action;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic signed [11:0] chan0;
    logic signed [11:0] chan1;
    logic signed [11:0] chan2;
    logic signed [11:0] chan3;
    logic signed [15:0] chan4;
    logic [3:0]         switches;
    logic signed [15:0] mouse_x;
    logic signed [15:0] mouse_y;
    logic signed [15:0] mouse_z;
    logic [15:0]        mouse_buttons;
    logic [15:0]        key_bits;
    logic               data_error;
  } out_item_t;

  typedef struct packed {
    logic [10:0] channel_offset;
    logic [10:0] channel_error_limit;
    logic [1:0]  switch_down_code;
  } cfg_t;

endpackage

/* design/dbus_decode.sv */
module dbus_decode (
  input  dbus_pkg::frame_t    frame_i,
  input  dbus_pkg::cfg_t      cfg_i,
  output dbus_pkg::out_item_t rec_o
);
  import dbus_pkg::*;

  logic [3:0][10:0] raw;
  logic [3:0][11:0] ch;
  logic [3:0][11:0] mag;
  logic [1:0]       s0, s1;
  logic [15:0]      ch4;
  logic             bad;

  // 11-bit channels packed lsb first across bytes 0 to 5
  assign raw[0] = {frame_i[1][2:0], frame_i[0]};
  assign raw[1] = {frame_i[2][5:0], frame_i[1][7:3]};
  assign raw[2] = {frame_i[4][0], frame_i[3], frame_i[2][7:6]};
  assign raw[3] = {frame_i[5][3:0], frame_i[4][7:1]};
  assign s0     = frame_i[5][5:4];
  assign s1     = frame_i[5][7:6];

  always_comb begin
    bad = (s0 == 2'd0) || (s1 == 2'd0);
    for (int k = 0; k < 4; k++) begin
      ch[k]  = {1'b0, raw[k]} - {1'b0, cfg_i.channel_offset};
      mag[k] = ch[k][11] ? (~ch[k] + 12'd1) : ch[k];
      if (mag[k] > {1'b0, cfg_i.channel_error_limit}) begin
        bad = 1'b1;
      end
    end
  end

  assign ch4 = {frame_i[17], frame_i[16]} - {5'd0, cfg_i.channel_offset};

  always_comb begin
    if (bad) begin
      rec_o            = '0;
      rec_o.switches   = {cfg_i.switch_down_code, cfg_i.switch_down_code};
      rec_o.data_error = 1'b1;
    end else begin
      rec_o.chan0         = ch[0];
      rec_o.chan1         = ch[1];
      rec_o.chan2         = ch[2];
      rec_o.chan3         = ch[3];
      rec_o.chan4         = ch4;
      rec_o.switches      = {s1, s0};
      rec_o.mouse_x       = {frame_i[7], frame_i[6]};
      rec_o.mouse_y       = {frame_i[9], frame_i[8]};
      rec_o.mouse_z       = {frame_i[11], frame_i[10]};
      rec_o.mouse_buttons = {frame_i[13], frame_i[12]};
      rec_o.key_bits      = {frame_i[15], frame_i[14]};
      rec_o.data_error    = 1'b0;
    end
  end

endmodule

/* design/dbus_remote_frame_decoder_unit.sv */
// channel   direction  handshake                payload
// in        input      in_valid_i / in_ready_o  in_item_i  (action, rx_byte)
// out       output     out_valid_o / out_ready_i out_item_o (decoded record)
// cfg       input      cfg_we_i                 cfg_index_i, cfg_wdata_i
//
// one transaction per cycle while in_ready_o is high; a byte is stored at the edge it is taken.
// an idle transaction after exactly 18 bytes loads the result register at its edge,
// so the record is offered in the cycle after; the decode is one pass from the store.
// reset clears the byte count and the output valid and restores register defaults.
// input stalls only while a record waits in the result register and out_ready_i is low.
module dbus_remote_frame_decoder_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  dbus_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output dbus_pkg::out_item_t out_item_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [10:0]         cfg_wdata_i
);
  import dbus_pkg::*;

  `include "assert_macros.svh"

  frame_t             frame_q;
  logic [COUNT_W-1:0] count_q, count_d;
  cfg_t               cfg_q;
  out_item_t          out_q, rec;
  logic               out_valid_q, out_valid_d;
  logic               in_fire, byte_fire, idle_fire, emit;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign byte_fire  = in_fire && (in_item_i.action == ACTION_BYTE);
  assign idle_fire  = in_fire && (in_item_i.action == ACTION_IDLE);
  assign emit       = idle_fire && (count_q == COUNT_W'(FRAME_BYTES));

  dbus_decode u_decode (
    .frame_i (frame_q),
    .cfg_i   (cfg_q),
    .rec_o   (rec)
  );

  always_comb begin
    count_d = count_q;
    if (idle_fire) begin
      count_d = '0;
    end else if (byte_fire && (count_q < COUNT_W'(BUFFER_BYTES))) begin
      count_d = count_q + COUNT_W'(1);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.channel_offset      <= OFFSET_RESET;
      cfg_q.channel_error_limit <= LIMIT_RESET;
      cfg_q.switch_down_code    <= SWDOWN_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_CHANNEL_OFFSET: cfg_q.channel_offset      <= cfg_wdata_i;
        REG_ERROR_LIMIT:    cfg_q.channel_error_limit <= cfg_wdata_i;
        REG_SWITCH_DOWN:    cfg_q.switch_down_code    <= cfg_wdata_i[1:0];
        default: ;
      endcase
    end
  end

  // bytes past the frame length are counted, up to the buffer size, but not kept
  always_ff @(posedge clk_i) begin
    if (byte_fire && (count_q < COUNT_W'(FRAME_BYTES))) begin
      frame_q[count_q[STORE_IDX_W-1:0]] <= in_item_i.rx_byte;
    end
    if (emit) begin
      out_q <= rec;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `ASSERT_NEXT(a_emit_valid, clk_i, rst_ni, emit, out_valid_q)
  `ASSERT_NEXT(a_idle_clears, clk_i, rst_ni, idle_fire, count_q == '0)
  `ASSERT_NEXT(a_count_step, clk_i, rst_ni,
    byte_fire && (count_q < COUNT_W'(BUFFER_BYTES)), count_q == $past(count_q) + COUNT_W'(1))
  `ASSERT_SAME(a_error_safe, clk_i, rst_ni, out_valid_q && out_q.data_error,
    (out_q.chan0 == '0) && (out_q.key_bits == '0) && (out_q.mouse_x == '0))

endmodule

/* dv/dbus_frame_checker.sv */
`timescale 1ns / 1ps

module dbus_frame_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  dbus_pkg::in_item_t  in_item_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  dbus_pkg::out_item_t out_item_i,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [10:0]         cfg_wdata_i,
  output int                  fail_count_o,
  output int                  pending_o
);
  import dbus_pkg::*;

  logic [7:0]         frame_mem [FRAME_BYTES];
  logic [COUNT_W-1:0] byte_tally;
  cfg_t               cfg;
  out_item_t          record_q [$];

  function automatic logic [11:0] magnitude12(input logic [11:0] v);
    return v[11] ? 12'(-v) : v;
  endfunction

  function automatic out_item_t decode_frame(input cfg_t c);
    logic [47:0] head;
    logic [10:0] raw [4];
    logic [11:0] chan [4];
    logic [1:0]  sw_l;
    logic [1:0]  sw_r;
    logic        bad;
    out_item_t   rec;
    head = {frame_mem[5], frame_mem[4], frame_mem[3],
            frame_mem[2], frame_mem[1], frame_mem[0]};
    sw_l = head[45:44];
    sw_r = head[47:46];
    bad  = (sw_l == 2'd0) || (sw_r == 2'd0);
    // four 11-bit sticks packed back to back from bit 0
    for (int k = 0; k < 4; k++) begin
      raw[k]  = head[11*k +: 11];
      chan[k] = {1'b0, raw[k]} - {1'b0, c.channel_offset};
      if (magnitude12(chan[k]) > {1'b0, c.channel_error_limit}) bad = 1'b1;
    end
    rec = '0;
    if (bad) begin
      rec.switches   = {c.switch_down_code, c.switch_down_code};
      rec.data_error = 1'b1;
    end else begin
      rec.chan0         = chan[0];
      rec.chan1         = chan[1];
      rec.chan2         = chan[2];
      rec.chan3         = chan[3];
      rec.chan4         = {frame_mem[17], frame_mem[16]} - {5'd0, c.channel_offset};
      rec.switches      = {sw_r, sw_l};
      rec.mouse_x       = {frame_mem[7], frame_mem[6]};
      rec.mouse_y       = {frame_mem[9], frame_mem[8]};
      rec.mouse_z       = {frame_mem[11], frame_mem[10]};
      rec.mouse_buttons = {frame_mem[13], frame_mem[12]};
      rec.key_bits      = {frame_mem[15], frame_mem[14]};
      rec.data_error    = 1'b0;
    end
    return rec;
  endfunction

  function automatic string show_record(input out_item_t r);
    return $sformatf("ch %0d %0d %0d %0d ch4 %0d sw %h mx %0d my %0d mz %0d btn %h key %h err %b",
                     r.chan0, r.chan1, r.chan2, r.chan3, r.chan4, r.switches,
                     r.mouse_x, r.mouse_y, r.mouse_z, r.mouse_buttons, r.key_bits,
                     r.data_error);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      byte_tally   = '0;
      cfg          = '{OFFSET_RESET, LIMIT_RESET, SWDOWN_RESET};
      record_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_CHANNEL_OFFSET: cfg.channel_offset      = cfg_wdata_i;
          REG_ERROR_LIMIT:    cfg.channel_error_limit = cfg_wdata_i;
          REG_SWITCH_DOWN:    cfg.switch_down_code    = cfg_wdata_i[1:0];
          default: ;
        endcase
      end
      // results leave before a new idle transaction can queue one
      if (out_valid_i && out_ready_i) begin
        if (record_q.size() == 0) begin
          if (fail_count_o < 10) $display("unexpected record: %s", show_record(out_item_i));
          fail_count_o++;
        end else begin
          want = record_q.pop_front();
          if (out_item_i !== want) begin
            if (fail_count_o < 10) begin
              $display("record mismatch at %0t", $realtime);
              $display("  expected %s", show_record(want));
              $display("  actual   %s", show_record(out_item_i));
            end
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (in_item_i.action == ACTION_BYTE) begin
          if (byte_tally < FRAME_BYTES) begin
            frame_mem[byte_tally[STORE_IDX_W-1:0]] = in_item_i.rx_byte;
          end
          if (byte_tally < BUFFER_BYTES) byte_tally++;
        end else begin
          if (byte_tally == FRAME_BYTES) record_q.push_back(decode_frame(cfg));
          byte_tally = '0;
        end
      end
      pending_o = record_q.size();
    end
  end

endmodule

/* dv/tb_dbus_remote_frame_decoder_unit.sv */
`timescale 1ns / 1ps

module tb_dbus_remote_frame_decoder_unit;
  import dbus_pkg::*;

  localparam logic [1:0] REG_UNUSED  = 2'd3;
  localparam int         PHASE_ITEMS = 210;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  in_item_t    in_item   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_item;
  logic        cfg_we    = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [10:0] cfg_wdata = '0;
  int          fail_count;
  int          pending;

  int          idle_pct  = 0;
  int          stall_pct = 0;
  int          items_sent = 0;
  logic [10:0] cur_off   = OFFSET_RESET;
  logic [10:0] cur_lim   = LIMIT_RESET;
  logic [7:0]  directed_frame [FRAME_BYTES];

  always #6 clk = ~clk;

  dbus_remote_frame_decoder_unit DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata)
  );

  dbus_frame_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_item_i    (in_item),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_item_i   (out_item),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_wdata_i  (cfg_wdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic send_item(input logic action, input logic [7:0] data);
    in_item_t item;
    item.action  = action;
    item.rx_byte = data;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic send_frame_bytes(input logic [7:0] fb [FRAME_BYTES]);
    for (int i = 0; i < FRAME_BYTES; i++) send_item(ACTION_BYTE, fb[i]);
    send_item(ACTION_IDLE, 8'($urandom));
  endtask

  task automatic send_burst(input int len);
    for (int i = 0; i < len; i++) send_item(ACTION_BYTE, 8'($urandom));
    send_item(ACTION_IDLE, 8'($urandom));
  endtask

  // stick value near the offset, often right on the limit edges
  function automatic logic [10:0] pick_channel();
    int d;
    case ($urandom_range(5))
      0: d = 0;
      1: d = int'(cur_lim);
      2: d = -int'(cur_lim);
      3: d = int'(cur_lim) + 1;
      4: d = -int'(cur_lim) - 1;
      default: d = int'($urandom_range(2 * int'(cur_lim))) - int'(cur_lim);
    endcase
    return 11'(int'(cur_off) + d);
  endfunction

  function automatic logic [1:0] pick_switch();
    return ($urandom_range(9) == 0) ? 2'd0 : 2'($urandom_range(1, 3));
  endfunction

  task automatic send_frame(input bit plausible);
    logic [7:0]  fb [FRAME_BYTES];
    logic [47:0] head;
    for (int i = 0; i < FRAME_BYTES; i++) fb[i] = 8'($urandom);
    if (plausible) begin
      head = {pick_switch(), pick_switch(),
              pick_channel(), pick_channel(), pick_channel(), pick_channel()};
      for (int i = 0; i < 6; i++) fb[i] = head[8*i +: 8];
    end
    send_frame_bytes(fb);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [10:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
  endtask

  task automatic write_cfg(input logic [10:0] off, input logic [10:0] lim,
                           input logic [1:0] swd);
    write_reg(REG_CHANNEL_OFFSET, off);
    write_reg(REG_ERROR_LIMIT, lim);
    write_reg(REG_SWITCH_DOWN, {9'($urandom), swd});
    // unmapped index must leave everything alone
    write_reg(REG_UNUSED, 11'($urandom));
    cfg_we  <= 1'b0;
    cur_off  = off;
    cur_lim  = lim;
    @(negedge clk);
  endtask

  task automatic drain(input int settle);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  initial begin
    logic [47:0] head;
    logic [10:0] off;
    logic [10:0] lim;
    logic [1:0]  swd;
    int          target;
    int          pick;
    int          len;

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: idle on an empty line, an extreme good frame, a short burst
    send_item(ACTION_IDLE, 8'hFF);
    head = {2'd3, 2'd1, cur_off, cur_off, cur_off, cur_off};
    for (int i = 0; i < 6; i++) directed_frame[i] = head[8*i +: 8];
    directed_frame[6]  = 8'hFF;
    directed_frame[7]  = 8'h7F;
    directed_frame[8]  = 8'h00;
    directed_frame[9]  = 8'h80;
    directed_frame[10] = 8'hFF;
    directed_frame[11] = 8'hFF;
    directed_frame[12] = 8'hFF;
    directed_frame[13] = 8'h00;
    directed_frame[14] = 8'hAA;
    directed_frame[15] = 8'h55;
    directed_frame[16] = 8'hFF;
    directed_frame[17] = 8'hFF;
    send_frame_bytes(directed_frame);
    send_burst(2);

    for (int p = 0; p < 8; p++) begin
      drain(4);
      case (p)
        0: begin off = OFFSET_RESET; lim = LIMIT_RESET; swd = SWDOWN_RESET; end
        1: begin off = 11'd0;    lim = 11'd0;    swd = 2'd0; end
        2: begin off = 11'd2047; lim = 11'd2047; swd = 2'd3; end
        3: begin off = 11'd0;    lim = 11'd2047; swd = 2'd1; end
        4: begin off = 11'd2047; lim = 11'd0;    swd = 2'd3; end
        7: begin off = 11'd1024; lim = 11'd2047; swd = 2'd1; end
        default: begin
          off = 11'($urandom);
          lim = 11'($urandom);
          swd = 2'($urandom);
        end
      endcase
      write_cfg(off, lim, swd);
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 75; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 75; end
        default: begin idle_pct = 13; stall_pct = 13; end
      endcase
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
        pick = $urandom_range(99);
        if (pick < 45) begin
          send_frame(1'b1);
        end else if (pick < 70) begin
          send_frame(1'b0);
        end else if (pick < 95) begin
          len = $urandom_range(2 * FRAME_BYTES + 8);
          if (len == FRAME_BYTES) len++;
          send_burst(len);
        end else begin
          // well past the buffer size, so the count has to stay saturated
          send_burst($urandom_range(60, 90));
        end
      end
    end

    drain(10);
    if (fail_count == 0) begin
      $display("dbus_remote_frame_decoder_unit test passed");
    end else begin
      $display("dbus_remote_frame_decoder_unit test failed");
    end
    $finish;
  end

  initial begin
    #(20_000_000);
    $display("dbus_remote_frame_decoder_unit test failed");
    $finish;
  end

endmodule

/* files.f */
+incdir+design
design/dbus_pkg.sv
design/dbus_decode.sv
design/dbus_remote_frame_decoder_unit.sv
dv/dbus_frame_checker.sv
dv/tb_dbus_remote_frame_decoder_unit.sv
